// ----- src/sm4_pkg.sv -----
`default_nettype none

package sm4_pkg;

	localparam int BLK_W   = 128;
	localparam int HALF_W  = 64;
	localparam int WORD_W  = 32;
	localparam int ROUNDS  = 32;
	localparam int RND_W   = $clog2(ROUNDS);
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_HI = 3'd0,
		CFG_KEY_LO = 3'd1,
		CFG_IV_HI  = 3'd2,
		CFG_IV_LO  = 3'd3,
		CFG_MODE   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic             capture;
		logic             key_load;
		logic             key_round;
		logic             blk_load;
		logic             blk_round;
		logic             finish;
		logic [RND_W-1:0] rnd;
	} sm4_cmd_t;

	typedef struct packed {
		logic key_write;
	} sm4_stat_t;

	localparam logic [WORD_W-1:0] FK0 = 32'hA3B1BAC6;
	localparam logic [WORD_W-1:0] FK1 = 32'h56AA3350;
	localparam logic [WORD_W-1:0] FK2 = 32'h677D9197;
	localparam logic [WORD_W-1:0] FK3 = 32'hB27022DC;

	localparam logic [7:0] SBOX [256] = '{
		8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
		8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
		8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
		8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
		8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
		8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
		8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
		8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
		8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
		8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
		8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
		8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
		8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
		8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
		8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
	};

	function automatic logic [WORD_W-1:0] subst(input logic [WORD_W-1:0] x);
		return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
	endfunction

	function automatic logic [WORD_W-1:0] lin_data(input logic [WORD_W-1:0] b);
		return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^
			{b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
	endfunction

	function automatic logic [WORD_W-1:0] lin_key(input logic [WORD_W-1:0] b);
		return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
	endfunction

	// Byte j of CK word i is (4i + j) * 7 modulo 256.
	function automatic logic [WORD_W-1:0] ck_word(input logic [RND_W-1:0] i);
		logic [WORD_W-1:0] w;
		logic [7:0]        base;
		w    = '0;
		base = {1'b0, i, 2'b00};
		for (int j = 0; j < 4; j++) begin
			w = {w[23:0], 8'((base + 8'(j)) * 8'd7)};
		end
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- src/sm4_ctrl.sv -----
`default_nettype none

module sm4_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire sm4_pkg::sm4_stat_t stat,
	output sm4_pkg::sm4_cmd_t       cmd
);
	import sm4_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY_LOAD,
		ST_KEY_RUN,
		ST_BLK_LOAD,
		ST_BLK_RUN,
		ST_FINISH
	} state_t;

	state_t           state_q;
	logic [RND_W-1:0] rnd_q;
	logic             stale_q;
	logic             out_valid_q;
	logic             slot_free;
	logic             last_rnd;

	assign slot_free = !out_valid_q || out_ready;
	assign last_rnd  = (rnd_q == RND_W'(ROUNDS - 1));
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.rnd       = rnd_q;
		cmd.capture   = (state_q == ST_IDLE) && in_valid;
		cmd.key_load  = (state_q == ST_KEY_LOAD);
		cmd.key_round = (state_q == ST_KEY_RUN);
		cmd.blk_load  = (state_q == ST_BLK_LOAD);
		cmd.blk_round = (state_q == ST_BLK_RUN);
		cmd.finish    = (state_q == ST_FINISH) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rnd_q       <= '0;
			stale_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (stat.key_write) begin
				stale_q <= 1'b1;
			end else if (state_q == ST_KEY_LOAD) begin
				stale_q <= 1'b0;
			end

			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= stale_q ? ST_KEY_LOAD : ST_BLK_LOAD;
					end
				end
				ST_KEY_LOAD: begin
					rnd_q   <= '0;
					state_q <= ST_KEY_RUN;
				end
				ST_KEY_RUN: begin
					rnd_q <= rnd_q + 1'b1;
					if (last_rnd) begin
						state_q <= ST_BLK_LOAD;
					end
				end
				ST_BLK_LOAD: begin
					rnd_q   <= '0;
					state_q <= ST_BLK_RUN;
				end
				ST_BLK_RUN: begin
					rnd_q <= rnd_q + 1'b1;
					if (last_rnd) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/sm4_dp.sv -----
`default_nettype none

module sm4_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [sm4_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sm4_pkg::HALF_W-1:0]  cfg_data,
	input  wire logic [sm4_pkg::BLK_W-1:0]   in_data,
	input  wire logic                        in_restart,
	input  wire logic                        in_last,
	input  wire sm4_pkg::sm4_cmd_t           cmd,
	output sm4_pkg::sm4_stat_t               stat,
	output logic [sm4_pkg::BLK_W-1:0]        out_data,
	output logic                             out_last
);
	import sm4_pkg::*;

	logic [HALF_W-1:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
	logic              enc_q;

	logic [HALF_W-1:0] chain_hi_q, chain_lo_q;
	logic [HALF_W-1:0] din_hi_q, din_lo_q;
	logic              last_q;
	logic              dec_q;

	logic [WORD_W-1:0] x_q [4];
	logic [WORD_W-1:0] rk_q [ROUNDS];

	logic [BLK_W-1:0]  res_q;
	logic              res_last_q;

	logic [RND_W-1:0]  rk_addr;
	logic [WORD_W-1:0] rnd_const;
	logic [WORD_W-1:0] sbox_out;
	logic [WORD_W-1:0] lin_out;
	logic [WORD_W-1:0] nx;
	logic [HALF_W-1:0] blk_hi, blk_lo;
	logic [HALF_W-1:0] fin_hi, fin_lo;

	assign stat.key_write = cfg_we &&
		(cfg_idx_t'(cfg_index) == CFG_KEY_HI || cfg_idx_t'(cfg_index) == CFG_KEY_LO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
			iv_hi_q  <= '0;
			iv_lo_q  <= '0;
			enc_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_KEY_HI: key_hi_q <= cfg_data;
				CFG_KEY_LO: key_lo_q <= cfg_data;
				CFG_IV_HI:  iv_hi_q  <= cfg_data;
				CFG_IV_LO:  iv_lo_q  <= cfg_data;
				CFG_MODE:   enc_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The shared round unit runs both the key schedule and the data rounds.
	assign rk_addr   = dec_q ? ~cmd.rnd : cmd.rnd;
	assign rnd_const = cmd.key_round ? ck_word(cmd.rnd) : rk_q[rk_addr];
	assign sbox_out  = subst(x_q[1] ^ x_q[2] ^ x_q[3] ^ rnd_const);
	assign lin_out   = cmd.key_round ? lin_key(sbox_out) : lin_data(sbox_out);
	assign nx        = x_q[0] ^ lin_out;

	assign blk_hi = dec_q ? din_hi_q : (din_hi_q ^ chain_hi_q);
	assign blk_lo = dec_q ? din_lo_q : (din_lo_q ^ chain_lo_q);
	assign fin_hi = {x_q[3], x_q[2]} ^ (dec_q ? chain_hi_q : HALF_W'(0));
	assign fin_lo = {x_q[1], x_q[0]} ^ (dec_q ? chain_lo_q : HALF_W'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_hi_q <= '0;
			chain_lo_q <= '0;
		end else if (cmd.capture && in_restart) begin
			chain_hi_q <= iv_hi_q;
			chain_lo_q <= iv_lo_q;
		end else if (cmd.finish) begin
			chain_hi_q <= dec_q ? din_hi_q : fin_hi;
			chain_lo_q <= dec_q ? din_lo_q : fin_lo;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			din_hi_q <= in_data[HALF_W-1:0];
			din_lo_q <= in_data[BLK_W-1:HALF_W];
			last_q   <= in_last;
			dec_q    <= !enc_q;
		end
		if (cmd.key_load) begin
			x_q[0] <= key_hi_q[63:32] ^ FK0;
			x_q[1] <= key_hi_q[31:0] ^ FK1;
			x_q[2] <= key_lo_q[63:32] ^ FK2;
			x_q[3] <= key_lo_q[31:0] ^ FK3;
		end else if (cmd.blk_load) begin
			x_q[0] <= blk_hi[63:32];
			x_q[1] <= blk_hi[31:0];
			x_q[2] <= blk_lo[63:32];
			x_q[3] <= blk_lo[31:0];
		end else if (cmd.key_round || cmd.blk_round) begin
			x_q[0] <= x_q[1];
			x_q[1] <= x_q[2];
			x_q[2] <= x_q[3];
			x_q[3] <= nx;
		end
		if (cmd.key_round) begin
			rk_q[cmd.rnd] <= nx;
		end
		if (cmd.finish) begin
			res_q      <= {fin_lo, fin_hi};
			res_last_q <= last_q;
		end
	end

	assign out_data = res_q;
	assign out_last = res_last_q;

endmodule

`default_nettype wire

// ----- src/sm4_cbc_cipher.sv -----
`default_nettype none

// Channel   Direction  Transaction
// s_axis    in         one 128-bit block, restart flag in tuser, message end in tlast
// m_axis    out        one 128-bit result block, message end in tlast
// cfg       in         register write, no handshake, one register per cycle
//
// A block goes from acceptance to its result register through a load step,
// 32 rounds of the shared round unit and a finish step that completes the chaining.
// The first block after reset or a key write first runs key expansion: a key load and 32 schedule rounds.
// A finished result waits in the output register while the next block is taken;
// that block then holds in its finish cycle until the waiting result is accepted.
// Reset clears control, configuration and the chaining value; round keys need none.
module sm4_cbc_cipher (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [sm4_pkg::BLK_W-1:0]     s_axis_tdata,  // data_low, data_high
	input  wire logic                          s_axis_tuser,  // restart_chain
	input  wire logic                          s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [sm4_pkg::BLK_W-1:0]          m_axis_tdata,  // result_low, result_high
	output logic                               m_axis_tlast,
	input  wire logic                          cfg_we,
	input  wire logic [sm4_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sm4_pkg::HALF_W-1:0]    cfg_data
);
	import sm4_pkg::*;

	sm4_cmd_t  cmd;
	sm4_stat_t stat;

	sm4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sm4_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_data    (s_axis_tdata),
		.in_restart (s_axis_tuser),
		.in_last    (s_axis_tlast),
		.cmd        (cmd),
		.stat       (stat),
		.out_data   (m_axis_tdata),
		.out_last   (m_axis_tlast)
	);

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.key_load, cmd.key_round,
			cmd.blk_load, cmd.blk_round, cmd.finish}))
		else $error("more than one datapath command at once");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !s_axis_tready)
		else $error("input taken while a block is in flight");

	a_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result register overwritten before it was taken");

	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(cmd.finish))
		else $error("result shown without a finished block");

endmodule

`default_nettype wire
